/* rtl/pkgate_pkg.sv */
package pkgate_pkg;

    localparam int PORT_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int IDLE_W    = 16;
    localparam int STAGE_W   = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [PORT_W-1:0]    port_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [IDLE_W-1:0]    idle_t;
    typedef logic [STAGE_W-1:0]   stage_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // item kinds
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // knock stages
    localparam stage_t STAGE_IDLE   = 2'd0;
    localparam stage_t STAGE_FIRST  = 2'd1;
    localparam stage_t STAGE_SECOND = 2'd2;
    localparam stage_t STAGE_OPEN   = 2'd3;

    // register indexes
    localparam cfg_idx_t CFG_KNOCK_FIRST  = 3'd0;
    localparam cfg_idx_t CFG_KNOCK_SECOND = 3'd1;
    localparam cfg_idx_t CFG_KNOCK_THIRD  = 3'd2;
    localparam cfg_idx_t CFG_GUARDED      = 3'd3;
    localparam cfg_idx_t CFG_IDLE_TIMEOUT = 3'd4;
    localparam cfg_idx_t CFG_EXEMPT       = 3'd5;

    // register reset values
    localparam port_t RST_KNOCK_FIRST  = 16'd2345;
    localparam port_t RST_KNOCK_SECOND = 16'd3456;
    localparam port_t RST_KNOCK_THIRD  = 16'd1233;
    localparam port_t RST_GUARDED      = 16'd1234;
    localparam idle_t RST_IDLE_TIMEOUT = 16'd1250;
    localparam port_t RST_EXEMPT       = 16'd22;

    localparam idle_t IDLE_MAX = {IDLE_W{1'b1}};

    typedef struct packed {
        port_t knock_first;
        port_t knock_second;
        port_t knock_third;
        port_t guarded;
        idle_t idle_timeout;
        port_t exempt;
    } cfg_t;

    typedef struct packed {
        stage_t stage;
        addr_t  source;
        idle_t  idle;
        logic   closing;
    } gate_state_t;

    typedef struct packed {
        logic  cmd;
        addr_t src_addr;
        port_t dst_port;
        logic  is_tcp;
        logic  fin_flag;
    } item_t;

endpackage

/* rtl/port_knock_gate.sv */
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------------------
// in       | in        | in_valid/in_ready  | cmd, src_addr, dst_port, is_tcp, fin_flag
// out      | out       | out_valid/out_ready| drop, stage_after
// cfg      | in        | cfg_we             | cfg_index, cfg_data
//
// one item per cycle while results are taken; a packet's result passes the input register,
// then the result register, and is held there until out_ready takes it
// ticks pass through the decision stage and give no result
// reset (rst_n, asynchronous) loads the default ports and clears the knock state
// a stalled result holds the decision stage; ticks behind it still drain
module port_knock_gate (
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  pkgate_pkg::addr_t    src_addr,
    input  pkgate_pkg::port_t    dst_port,
    input  logic                 is_tcp,
    input  logic                 fin_flag,
    // result items
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 drop,
    output pkgate_pkg::stage_t   stage_after,
    // configuration writes
    input  logic                 cfg_we,
    input  pkgate_pkg::cfg_idx_t cfg_index,
    input  pkgate_pkg::port_t    cfg_data
);
    import pkgate_pkg::*;

    cfg_t        cfg;
    item_t       item_reg;
    logic        item_valid_reg;
    gate_state_t state_reg;
    gate_state_t state_next;
    logic        drop_next;
    logic        out_valid_reg;
    logic        drop_reg;
    stage_t      stage_reg;
    logic        item_is_tick;
    logic        item_adv;
    logic        item_emit;

    // configuration registers
    pkgate_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // per-item rule evaluation against the current knock state
    pkgate_decide u_decide (
        .cfg        (cfg),
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .drop       (drop_next)
    );

    // the item in the input register leaves when its result has somewhere to go;
    // a tick has no result so it always leaves
    assign item_is_tick = (item_reg.cmd == CMD_TICK);
    assign item_adv     = item_valid_reg && (item_is_tick || !out_valid_reg || out_ready);
    assign item_emit    = item_adv && !item_is_tick;
    assign in_ready     = !item_valid_reg || item_adv;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd      <= cmd;
            item_reg.src_addr <= src_addr;
            item_reg.dst_port <= dst_port;
            item_reg.is_tcp   <= is_tcp;
            item_reg.fin_flag <= fin_flag;
        end
    end

    // knock state: updated once per item as it leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (item_adv)
        begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (item_emit)
        begin
            drop_reg  <= drop_next;
            stage_reg <= state_next.stage;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drop        = drop_reg;
    assign stage_after = stage_reg;

    // a result only ever comes from a packet leaving the input register
    a_result_from_packet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(item_emit))
        else $error("result appeared without a packet");

    // the idle counter only counts up by one or clears
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.idle != $past(state_reg.idle)) |->
            (state_reg.idle == '0) || (state_reg.idle == $past(state_reg.idle) + idle_t'(1)))
        else $error("idle counter jumped");

    // back-pressure on the input only while a packet waits behind a stalled result
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && !item_is_tick && out_valid_reg && !out_ready))
        else $error("input stalled without cause");

    // a packet held behind a stalled result leaves the knock state alone
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !item_is_tick && out_valid_reg && !out_ready) |=>
            $stable(state_reg))
        else $error("knock state changed during stall");

endmodule

/* rtl/pkgate_cfg.sv */
module pkgate_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  pkgate_pkg::cfg_idx_t cfg_index,
    input  pkgate_pkg::port_t    cfg_data,
    output pkgate_pkg::cfg_t     cfg
);
    import pkgate_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.knock_first  <= RST_KNOCK_FIRST;
            cfg_reg.knock_second <= RST_KNOCK_SECOND;
            cfg_reg.knock_third  <= RST_KNOCK_THIRD;
            cfg_reg.guarded      <= RST_GUARDED;
            cfg_reg.idle_timeout <= RST_IDLE_TIMEOUT;
            cfg_reg.exempt       <= RST_EXEMPT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KNOCK_FIRST:  cfg_reg.knock_first  <= cfg_data;
                CFG_KNOCK_SECOND: cfg_reg.knock_second <= cfg_data;
                CFG_KNOCK_THIRD:  cfg_reg.knock_third  <= cfg_data;
                CFG_GUARDED:      cfg_reg.guarded      <= cfg_data;
                CFG_IDLE_TIMEOUT: cfg_reg.idle_timeout <= cfg_data;
                CFG_EXEMPT:       cfg_reg.exempt       <= cfg_data;
                default:          ; // unused index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pkgate_decide.sv */
module pkgate_decide (
    input  pkgate_pkg::cfg_t        cfg,
    input  pkgate_pkg::item_t       item,
    input  pkgate_pkg::gate_state_t state_cur,
    output pkgate_pkg::gate_state_t state_next,
    output logic                    drop
);
    import pkgate_pkg::*;

    logic same;

    assign same = (item.src_addr == state_cur.source);

    always_comb
    begin
        state_next = state_cur;
        drop       = 1'b0;
        if (item.cmd == CMD_TICK)
        begin
            if (state_cur.idle != IDLE_MAX)
            begin
                state_next.idle = state_cur.idle + idle_t'(1);
            end
        end
        else if (item.is_tcp)
        begin
            // first matching port decides
            priority if (item.dst_port == cfg.knock_first)
            begin
                state_next.source = item.src_addr;
                state_next.stage  = STAGE_FIRST;
            end
            else if (item.dst_port == cfg.knock_second)
            begin
                if (same)
                begin
                    state_next.stage = (state_cur.stage == STAGE_FIRST) ? STAGE_SECOND
                                                                        : STAGE_IDLE;
                end
            end
            else if (item.dst_port == cfg.knock_third)
            begin
                if (same)
                begin
                    if (state_cur.stage == STAGE_SECOND)
                    begin
                        state_next.stage = STAGE_OPEN;
                        state_next.idle  = '0;
                    end
                    else
                    begin
                        state_next.stage = STAGE_IDLE;
                    end
                end
            end
            else if (item.dst_port == cfg.guarded)
            begin
                drop = 1'b1;
                if (same)
                begin
                    priority if (state_cur.closing)
                    begin
                        // last packet after fin
                        state_next.closing = 1'b0;
                        state_next.stage   = STAGE_IDLE;
                        drop               = 1'b0;
                    end
                    else if (state_cur.stage == STAGE_OPEN)
                    begin
                        if (state_cur.idle > cfg.idle_timeout)
                        begin
                            state_next.stage = STAGE_IDLE;
                        end
                        else
                        begin
                            state_next.idle = '0;
                            if (item.fin_flag)
                            begin
                                state_next.closing = 1'b1;
                            end
                            drop = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next.stage = STAGE_IDLE;
                    end
                end
            end
            else
            begin
                if (same && (item.dst_port != cfg.exempt))
                begin
                    state_next.stage = STAGE_IDLE;
                end
            end
        end
    end

endmodule

/* dv/port_knock_gate_tb.sv */
`timescale 1ns / 100ps

module port_knock_gate_tb;

    import pkgate_pkg::*;

    // drop flag and knock stage that one packet should produce
    typedef struct packed {
        logic   drop;
        stage_t stage;
    } verdict_t;

    // dut ports, all inputs known from time zero
    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     in_valid    = 1'b0;
    logic     in_ready;
    logic     cmd         = CMD_PACKET;
    addr_t    src_addr    = '0;
    port_t    dst_port    = '0;
    logic     is_tcp      = 1'b0;
    logic     fin_flag    = 1'b0;
    logic     out_valid;
    logic     out_ready   = 1'b0;
    logic     drop;
    stage_t   stage_after;
    logic     cfg_we      = 1'b0;
    cfg_idx_t cfg_index   = '0;
    port_t    cfg_data    = '0;

    // items waiting for the driver, and verdicts waiting for the dut
    item_t    pending_items[$];
    verdict_t expected_verdicts[$];

    // predictor copy of the registers and of the knock state
    cfg_t        regs;
    gate_state_t gate = '0;

    // bookkeeping shared by driver, monitor and the sequence
    int  queued_total   = 0;
    int  accepted_total = 0;
    int  error_count    = 0;
    bit  in_fired       = 1'b0;
    int  send_idle_pct  = 22;
    int  recv_idle_pct  = 68;
    item_t drv_item;

    // sources that the knock sequences are built from
    addr_t src_pool[4];

    port_knock_gate dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .src_addr    (src_addr),
        .dst_port    (dst_port),
        .is_tcp      (is_tcp),
        .fin_flag    (fin_flag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drop        (drop),
        .stage_after (stage_after),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: applies one accepted item to the gate state and queues
    // the verdict a packet should give; ticks only age the idle counter
    // ------------------------------------------------------------------
    task automatic update_gate(item_t it);
        logic same;
        logic blocked;
        if (it.cmd == CMD_TICK)
        begin
            // saturating, so a long silence never wraps back into the window
            if (gate.idle != IDLE_MAX)
                gate.idle = gate.idle + idle_t'(1);
            return;
        end
        blocked = 1'b0;
        // non-tcp traffic passes untouched
        if (it.is_tcp)
        begin
            same = (it.src_addr == gate.source);
            // port tests in priority order, first match decides
            if (it.dst_port == regs.knock_first)
            begin
                // any source may (re)register, closing is left alone
                gate.source = it.src_addr;
                gate.stage  = STAGE_FIRST;
            end
            else if (it.dst_port == regs.knock_second)
            begin
                if (same)
                    gate.stage = (gate.stage == STAGE_FIRST) ? STAGE_SECOND : STAGE_IDLE;
            end
            else if (it.dst_port == regs.knock_third)
            begin
                if (same)
                begin
                    if (gate.stage == STAGE_SECOND)
                    begin
                        gate.stage = STAGE_OPEN;
                        gate.idle  = '0;
                    end
                    else
                        gate.stage = STAGE_IDLE;
                end
            end
            else if (it.dst_port == regs.guarded)
            begin
                // strangers are dropped without touching the state
                blocked = 1'b1;
                if (same)
                begin
                    if (gate.closing)
                    begin
                        // the one packet allowed after a fin
                        gate.closing = 1'b0;
                        gate.stage   = STAGE_IDLE;
                        blocked      = 1'b0;
                    end
                    else if (gate.stage == STAGE_OPEN)
                    begin
                        if (gate.idle > regs.idle_timeout)
                            gate.stage = STAGE_IDLE;
                        else
                        begin
                            gate.idle = '0;
                            if (it.fin_flag)
                                gate.closing = 1'b1;
                            blocked = 1'b0;
                        end
                    end
                    else
                        gate.stage = STAGE_IDLE;
                end
            end
            else if (same && it.dst_port != regs.exempt)
                gate.stage = STAGE_IDLE;
        end
        expected_verdicts.push_back('{drop: blocked, stage: gate.stage});
    endtask

    // ------------------------------------------------------------------
    // driver: inputs change on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // a held item may only move on once it has been taken
        if (!in_valid || in_fired)
        begin
            in_fired = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = pending_items.pop_front();
                in_valid <= 1'b1;
                cmd      <= drv_item.cmd;
                src_addr <= drv_item.src_addr;
                dst_port <= drv_item.dst_port;
                is_tcp   <= drv_item.is_tcp;
                fin_flag <= drv_item.fin_flag;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        if (in_valid && in_ready)
        begin
            update_gate('{cmd, src_addr, dst_port, is_tcp, fin_flag});
            accepted_total++;
            in_fired = 1'b1;
        end
        if (out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result item with none expected: drop %0d stage_after %0d",
                       drop, stage_after);
                error_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (drop !== want.drop)
                begin
                    $error("drop: expected %0d, actual %0d", want.drop, drop);
                    error_count++;
                end
                if (stage_after !== want.stage)
                begin
                    $error("stage_after: expected %0d, actual %0d", want.stage, stage_after);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic c, addr_t a, port_t p, logic t, logic f);
        pending_items.push_back('{cmd: c, src_addr: a, dst_port: p, is_tcp: t, fin_flag: f});
        queued_total++;
    endtask

    task automatic add_packet(addr_t a, port_t p, logic t = 1'b1, logic f = 1'b0);
        add_item(CMD_PACKET, a, p, t, f);
    endtask

    // tick payload is don't-care, so scramble it
    task automatic add_ticks(int n);
        repeat (n)
            add_item(CMD_TICK, addr_t'($urandom), port_t'($urandom), 1'($urandom),
                     1'($urandom));
    endtask

    // the whole knock sequence from one source
    task automatic add_knocks(addr_t a);
        add_packet(a, regs.knock_first);
        add_packet(a, regs.knock_second);
        add_packet(a, regs.knock_third);
    endtask

    // register write, mirrored straight into the predictor (block is idle)
    task automatic write_reg(cfg_idx_t idx, port_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_KNOCK_FIRST:  regs.knock_first  = val;
            CFG_KNOCK_SECOND: regs.knock_second = val;
            CFG_KNOCK_THIRD:  regs.knock_third  = val;
            CFG_GUARDED:      regs.guarded      = val;
            CFG_IDLE_TIMEOUT: regs.idle_timeout = val;
            CFG_EXEMPT:       regs.exempt       = val;
            default:          ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(port_t k1, port_t k2, port_t k3, port_t g, idle_t tmo, port_t ex);
        write_reg(CFG_KNOCK_FIRST, k1);
        write_reg(CFG_KNOCK_SECOND, k2);
        write_reg(CFG_KNOCK_THIRD, k3);
        write_reg(CFG_GUARDED, g);
        write_reg(CFG_IDLE_TIMEOUT, tmo);
        write_reg(CFG_EXEMPT, ex);
    endtask

    // mostly one of the configured ports, sometimes anything at all
    function automatic port_t pick_port();
        case ($urandom_range(7))
            0:       return regs.knock_first;
            1:       return regs.knock_second;
            2:       return regs.knock_third;
            3:       return regs.guarded;
            4:       return regs.exempt;
            5:       return port_t'($urandom);
            6:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return port_t'($urandom);
        endcase
    endfunction

    // quiet spells; now and then long enough to run past a short timeout
    function automatic int gap_ticks();
        if (regs.idle_timeout <= 64 && $urandom_range(7) == 0)
            return int'(regs.idle_timeout) + $urandom_range(0, 2);
        return $urandom_range(0, 2);
    endfunction

    // one stray or broken item
    task automatic add_noise();
        addr_t a;
        a = src_pool[$urandom_range(3)];
        case ($urandom_range(5))
            0: add_ticks(1);
            1: add_packet($urandom, pick_port(), 1'b0, 1'($urandom_range(1)));
            2: add_packet($urandom, port_t'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            // out of order second or third knock
            3: add_packet(a, ($urandom_range(1) ? regs.knock_second : regs.knock_third),
                          1'b1, 1'($urandom_range(1)));
            4: add_packet(a, regs.exempt, 1'b1, 1'($urandom_range(1)));
            // someone else grabs the registration
            default: add_packet($urandom, regs.knock_first, 1'b1, 1'($urandom_range(1)));
        endcase
    endtask

    // mostly complete knock-and-use sessions, the rest noise
    task automatic add_random_traffic(int n);
        int    start;
        addr_t a;
        start = queued_total;
        src_pool[0] = '0;
        src_pool[1] = $urandom;
        src_pool[2] = $urandom;
        src_pool[3] = '1;
        while (queued_total - start < n)
        begin
            if ($urandom_range(99) < 65)
            begin
                a = src_pool[$urandom_range(3)];
                add_packet(a, regs.knock_first, 1'b1, 1'($urandom_range(1)));
                if ($urandom_range(7) == 0)
                    add_noise();
                add_ticks($urandom_range(0, 1));
                add_packet(a, regs.knock_second, 1'b1, 1'($urandom_range(1)));
                if ($urandom_range(11) == 0)
                    add_noise();
                add_ticks($urandom_range(0, 1));
                add_packet(a, regs.knock_third, 1'b1, 1'($urandom_range(1)));
                repeat ($urandom_range(1, 5))
                begin
                    add_ticks(gap_ticks());
                    if ($urandom_range(5) == 0)
                        add_packet(a, regs.exempt, 1'b1, 1'($urandom_range(1)));
                    add_packet(a, regs.guarded, 1'b1, ($urandom_range(3) == 0));
                end
            end
            else
                add_noise();
        end
    endtask

    // everything taken, every verdict seen, then a wait for ticks in flight
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_total != queued_total || expected_verdicts.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        regs = '{knock_first:  RST_KNOCK_FIRST,
                 knock_second: RST_KNOCK_SECOND,
                 knock_third:  RST_KNOCK_THIRD,
                 guarded:      RST_GUARDED,
                 idle_timeout: RST_IDLE_TIMEOUT,
                 exempt:       RST_EXEMPT};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: sender idles lightly, receiver heavily
        add_ticks(1);
        // address zero matches the cleared source, guarded port before knocking
        add_packet(32'h0, RST_GUARDED);
        add_packet(32'h0, RST_GUARDED, 1'b0, 1'b1);
        add_knocks(32'hFFFF_FFFF);
        // stranger on the guarded port while open
        add_packet(32'h1234_5678, RST_GUARDED);
        add_packet(32'hFFFF_FFFF, RST_GUARDED);
        add_packet(32'hFFFF_FFFF, RST_EXEMPT);
        // fin, then a first knock that must not cancel closing
        add_packet(32'hFFFF_FFFF, RST_GUARDED, 1'b1, 1'b1);
        add_packet(32'hFFFF_FFFF, RST_KNOCK_FIRST);
        add_packet(32'hFFFF_FFFF, RST_GUARDED);
        add_packet(32'hFFFF_FFFF, 16'hFFFF);
        add_packet(32'hFFFF_FFFF, RST_KNOCK_SECOND);
        add_packet(32'hFFFF_FFFF, RST_KNOCK_THIRD);
        add_packet(32'h0, RST_KNOCK_FIRST);
        add_packet(32'h0, 16'h0000);
        add_random_traffic(400);
        wait_drained();

        // extreme ports, zero timeout, roles of the idle rates swapped
        send_idle_pct = 68;
        recv_idle_pct = 22;
        write_all(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'd0, 16'h8000);
        add_knocks(32'h0A00_0001);
        add_packet(32'h0A00_0001, 16'hFFFE);
        // a single tick is already past a zero timeout
        add_ticks(1);
        add_packet(32'h0A00_0001, 16'hFFFE);
        add_random_traffic(400);
        wait_drained();

        // coinciding registers, earlier tests win; no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(16'd100, 16'd100, 16'd200, 16'd200, 16'd5, 16'd200);
        add_packet(32'h5555_AAAA, 16'd100);
        add_packet(32'h5555_AAAA, 16'd100);
        add_packet(32'h5555_AAAA, 16'd200);
        add_random_traffic(300);
        wait_drained();

        // timeout one below the largest value: the gate stays open across a quiet spell
        write_all(16'hFFFF, 16'h0000, 16'd7, 16'd8, 16'd65534, 16'd9);
        add_knocks(32'hC0A8_0101);
        add_ticks(40);
        add_packet(32'hC0A8_0101, 16'd8);
        add_random_traffic(300);
        wait_drained();

        // scrambled ports with a short timeout
        write_all(port_t'($urandom), port_t'($urandom), port_t'($urandom), port_t'($urandom),
                  16'd12, port_t'($urandom));
        add_random_traffic(300);
        wait_drained();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* port_knock_gate.f */
rtl/pkgate_pkg.sv
rtl/pkgate_cfg.sv
rtl/pkgate_decide.sv
rtl/port_knock_gate.sv
dv/port_knock_gate_tb.sv
